>>> rtl/nv12_overlay_alpha_blend_core_macros.svh
// Assertion macros shared by the overlay blend checker
`ifndef NV12_OVERLAY_ALPHA_BLEND_CORE_MACROS_SVH
`define NV12_OVERLAY_ALPHA_BLEND_CORE_MACROS_SVH

// check cons in the same cycle as ante
`define NVOB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nvob: same-cycle check failed");

// check cons in the cycle after ante
`define NVOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nvob: next-cycle check failed");

`endif

>>> rtl/nvob_pkg.sv
// Types, constants and arithmetic helpers for the NV12 overlay blend
`default_nettype none
package nvob_pkg;

	typedef struct packed {
		logic [31:0] top_left_bgra;
		logic [31:0] top_right_bgra;
		logic [31:0] bottom_left_bgra;
		logic [31:0] bottom_right_bgra;
		logic [7:0]  top_left_luma;
		logic [7:0]  top_right_luma;
		logic [7:0]  bottom_left_luma;
		logic [7:0]  bottom_right_luma;
		logic [7:0]  chroma_u_in;
		logic [7:0]  chroma_v_in;
	} nvob_in_req_t;

	typedef struct packed {
		logic [7:0] blended_top_left_luma;
		logic [7:0] blended_top_right_luma;
		logic [7:0] blended_bottom_left_luma;
		logic [7:0] blended_bottom_right_luma;
		logic [7:0] chroma_u_out;
		logic [7:0] chroma_v_out;
	} nvob_out_req_t;

	localparam logic [15:0] Y_COEF_R = 16'd47;
	localparam logic [15:0] Y_COEF_G = 16'd157;
	localparam logic [15:0] Y_COEF_B = 16'd16;
	localparam logic [15:0] Y_ROUND  = 16'd128;

	localparam logic signed [15:0] U_COEF_R = 16'sd26;
	localparam logic signed [15:0] U_COEF_G = 16'sd87;
	localparam logic signed [15:0] U_COEF_B = 16'sd112;
	localparam logic signed [15:0] V_COEF_R = 16'sd112;
	localparam logic signed [15:0] V_COEF_G = 16'sd102;
	localparam logic signed [15:0] V_COEF_B = 16'sd10;
	localparam logic signed [15:0] C_ROUND  = 16'sd128;

	localparam logic [7:0] Y_OFFSET   = 8'd16;
	localparam logic [7:0] Y_MIN      = 8'd16;
	localparam logic [7:0] Y_MAX      = 8'd235;
	localparam logic [7:0] C_OFFSET   = 8'd128;
	localparam logic [7:0] C_MIN      = 8'd16;
	localparam logic [7:0] C_MAX      = 8'd240;
	localparam logic [7:0] ALPHA_MAX  = 8'd255;
	localparam logic [7:0] CHAN_MAX   = 8'd255;

	localparam logic [15:0] L_ROUND   = 16'd127;
	localparam logic [17:0] CH_ROUND  = 18'd510;
	localparam logic [9:0]  CH_WEIGHT = 10'd1020;

	// one restoring division step: {remainder, quotient bit}
	function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
			input logic [7:0] den);
		logic [8:0] t;
		t = {rem, nbit};
		if (t >= {1'b0, den}) begin
			t = t - {1'b0, den};
			return {t[7:0], 1'b1};
		end
		return {t[7:0], 1'b0};
	endfunction

	// exact floor(x / 255) for quotients up to 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

>>> rtl/nvob_unpremul.sv
// Pipelined un-premultiply of one colour channel, two quotient bits per stage
`default_nettype none
module nvob_unpremul import nvob_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic       pm,
	input  logic [7:0] chan,
	input  logic [7:0] alpha,
	output logic [7:0] result
);

	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] lo;
		logic [7:0] quo;
		logic [7:0] den;
		logic [7:0] chan;
		logic       byp;
		logic       sat;
	} div_t;

	function automatic div_t advance(input div_t x);
		div_t y;
		logic [8:0] st;
		y = x;
		for (int i = 0; i < 2; i++) begin
			st    = div_step(y.rem, y.lo[7], y.den);
			y.rem = st[8:1];
			y.quo = {y.quo[6:0], st[0]};
			y.lo  = {y.lo[6:0], 1'b0};
		end
		return y;
	endfunction

	logic [15:0] num;
	div_t        init;
	div_t        d_s1, d_s2, d_s3, d_s4, d_s5;

	always_comb begin
		num       = {chan, 8'd0} - {8'd0, chan} + {9'd0, alpha[7:1]};
		init.rem  = num[15:8];
		init.lo   = num[7:0];
		init.quo  = '0;
		init.den  = alpha;
		init.chan = chan;
		init.byp  = !pm || (alpha == '0);
		init.sat  = chan >= alpha;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= init;
			d_s2 <= advance(d_s1);
			d_s3 <= advance(d_s2);
			d_s4 <= advance(d_s3);
			d_s5 <= advance(d_s4);
		end
	end

	assign result = d_s5.byp ? d_s5.chan : (d_s5.sat ? CHAN_MAX : d_s5.quo);

endmodule
`default_nettype wire

>>> rtl/nv12_overlay_alpha_blend_core.sv
// Top level of the NV12 overlay alpha blend pipeline
// Usage:
//   The src channel takes one 2x2 quad per request: four BGRA overlay pixels,
//   the four destination luma bytes and the shared U/V pair. The dst channel
//   returns the four blended luma bytes and the blended U/V pair.
//   A request is taken at a clock edge with src_valid high and src_stall low;
//   a result is taken at an edge with dst_valid high and dst_stall low.
//   cfg_we writes cfg_wdata into the premultiplied-alpha register; write it
//   only while no request is in flight.
//   Nine register stages; one quad per cycle is sustained while the receiver
//   does not stall a waiting result. Five stages hold the un-premultiply
//   dividers: one loads the dividend, four resolve two quotient bits each;
//   the rest convert, weight, sum and scale by 1/255.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and src_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and the register; no clearing pass is needed.
`default_nettype none
module nv12_overlay_alpha_blend_core import nvob_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	input  nvob_in_req_t  src_req,
	output logic          dst_valid,
	input  logic          dst_stall,
	output nvob_out_req_t dst_req,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);

	localparam int LAT = 9;

	typedef struct packed {
		logic [3:0][7:0] alpha;
		logic [3:0][7:0] luma;
		logic [7:0]      du;
		logic [7:0]      dv;
	} side_t;

	logic            pm_q;
	logic [LAT-1:0]  vld_q;
	logic            en;

	logic [31:0]     px [4];
	logic [7:0]      col [4][3];
	side_t           side_in;
	side_t           side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic [15:0]        ysum [4];
	logic signed [15:0] su [4];
	logic signed [15:0] sv [4];
	logic [9:0]         asum;
	logic [15:0]        ysum_s6 [4];
	logic signed [15:0] su_s6 [4];
	logic signed [15:0] sv_s6 [4];
	logic [9:0]         asum_s6;

	logic [7:0]  yc [4];
	logic [7:0]  uc [4];
	logic [7:0]  vc [4];
	logic [7:0]  yr, ur, vr;
	logic [15:0] ya_s7 [4];
	logic [15:0] dd_s7 [4];
	logic [15:0] ua_s7 [4];
	logic [15:0] va_s7 [4];
	logic [17:0] dup_s7, dvp_s7;

	logic [15:0] lx_s8 [4];
	logic [17:0] cu_s8, cv_s8;
	nvob_out_req_t out_s9;

	assign en        = !(dst_valid && dst_stall);
	assign src_stall = !en;
	assign dst_valid = vld_q[LAT-1];
	assign dst_req   = out_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q  <= 1'b0;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				pm_q <= cfg_wdata;
			end
			if (en) begin
				vld_q <= {vld_q[LAT-2:0], src_valid};
			end
		end
	end

	assign px[0] = src_req.top_left_bgra;
	assign px[1] = src_req.top_right_bgra;
	assign px[2] = src_req.bottom_left_bgra;
	assign px[3] = src_req.bottom_right_bgra;

	always_comb begin
		for (int p = 0; p < 4; p++) begin
			side_in.alpha[p] = px[p][31:24];
		end
		side_in.luma[0] = src_req.top_left_luma;
		side_in.luma[1] = src_req.top_right_luma;
		side_in.luma[2] = src_req.bottom_left_luma;
		side_in.luma[3] = src_req.bottom_right_luma;
		side_in.du      = src_req.chroma_u_in;
		side_in.dv      = src_req.chroma_v_in;
	end

	for (genvar p = 0; p < 4; p++) begin : g_pix
		for (genvar c = 0; c < 3; c++) begin : g_chan
			nvob_unpremul u_unpremul (
				.clk    (clk),
				.en     (en),
				.pm     (pm_q),
				.chan   (px[p][8*c +: 8]),
				.alpha  (px[p][31:24]),
				.result (col[p][c])
			);
		end
	end

	// colour order in col: blue, green, red
	always_comb begin
		asum = '0;
		for (int p = 0; p < 4; p++) begin
			ysum[p] = {8'd0, col[p][2]} * Y_COEF_R + {8'd0, col[p][1]} * Y_COEF_G
				+ {8'd0, col[p][0]} * Y_COEF_B + Y_ROUND;
			su[p] = $signed({8'd0, col[p][0]}) * U_COEF_B
				- $signed({8'd0, col[p][2]}) * U_COEF_R
				- $signed({8'd0, col[p][1]}) * U_COEF_G + C_ROUND;
			sv[p] = $signed({8'd0, col[p][2]}) * V_COEF_R
				- $signed({8'd0, col[p][1]}) * V_COEF_G
				- $signed({8'd0, col[p][0]}) * V_COEF_B + C_ROUND;
			asum = asum + {2'd0, side_s5.alpha[p]};
		end
	end

	always_comb begin
		for (int p = 0; p < 4; p++) begin
			yr = ysum_s6[p][15:8] + Y_OFFSET;
			ur = su_s6[p][15:8] + C_OFFSET;
			vr = sv_s6[p][15:8] + C_OFFSET;
			yc[p] = (yr < Y_MIN) ? Y_MIN : ((yr > Y_MAX) ? Y_MAX : yr);
			uc[p] = (ur < C_MIN) ? C_MIN : ((ur > C_MAX) ? C_MAX : ur);
			vc[p] = (vr < C_MIN) ? C_MIN : ((vr > C_MAX) ? C_MAX : vr);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;

			for (int p = 0; p < 4; p++) begin
				ysum_s6[p] <= ysum[p];
				su_s6[p]   <= su[p];
				sv_s6[p]   <= sv[p];
			end
			asum_s6 <= asum;

			for (int p = 0; p < 4; p++) begin
				ya_s7[p] <= {8'd0, yc[p]} * {8'd0, side_s6.alpha[p]};
				dd_s7[p] <= {8'd0, side_s6.luma[p]} * {8'd0, ALPHA_MAX - side_s6.alpha[p]};
				ua_s7[p] <= {8'd0, uc[p]} * {8'd0, side_s6.alpha[p]};
				va_s7[p] <= {8'd0, vc[p]} * {8'd0, side_s6.alpha[p]};
			end
			dup_s7 <= {10'd0, side_s6.du} * {8'd0, CH_WEIGHT - asum_s6};
			dvp_s7 <= {10'd0, side_s6.dv} * {8'd0, CH_WEIGHT - asum_s6};

			for (int p = 0; p < 4; p++) begin
				lx_s8[p] <= ya_s7[p] + dd_s7[p] + L_ROUND;
			end
			cu_s8 <= {2'd0, ua_s7[0]} + {2'd0, ua_s7[1]} + {2'd0, ua_s7[2]}
				+ {2'd0, ua_s7[3]} + dup_s7 + CH_ROUND;
			cv_s8 <= {2'd0, va_s7[0]} + {2'd0, va_s7[1]} + {2'd0, va_s7[2]}
				+ {2'd0, va_s7[3]} + dvp_s7 + CH_ROUND;

			out_s9.blended_top_left_luma     <= div255(lx_s8[0]);
			out_s9.blended_top_right_luma    <= div255(lx_s8[1]);
			out_s9.blended_bottom_left_luma  <= div255(lx_s8[2]);
			out_s9.blended_bottom_right_luma <= div255(lx_s8[3]);
			out_s9.chroma_u_out              <= div255(cu_s8[17:2]);
			out_s9.chroma_v_out              <= div255(cv_s8[17:2]);
		end
	end

endmodule
`default_nettype wire

>>> rtl/nvob_checker.sv
// Port-level checker for the NV12 overlay blend core, bound to the top level
`default_nettype none
`include "nv12_overlay_alpha_blend_core_macros.svh"
module nvob_checker import nvob_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          src_stall,
	input logic          dst_valid,
	input logic          dst_stall,
	input nvob_out_req_t dst_req
);

	`NVOB_ASSERT_NEXT(a_held_result, clk, arst_n, dst_valid && dst_stall, dst_valid && $stable(dst_req))
	`NVOB_ASSERT_SAME(a_stall_cause, clk, arst_n, src_stall, dst_valid && dst_stall)
	`NVOB_ASSERT_SAME(a_backpressure, clk, arst_n, dst_valid && dst_stall, src_stall)
	`NVOB_ASSERT_SAME(a_drop_after_take, clk, arst_n, $fell(dst_valid), $past(!dst_stall))

endmodule

bind nv12_overlay_alpha_blend_core nvob_checker u_nvob_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_stall (src_stall),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.dst_req   (dst_req)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the NV12 overlay alpha blend core
module testbench;
	import nvob_pkg::*;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          src_valid = 1'b0;
	logic          src_stall;
	nvob_in_req_t  src_req = '0;
	logic          dst_valid;
	logic          dst_stall = 1'b0;
	nvob_out_req_t dst_req;
	logic          cfg_we = 1'b0;
	logic          cfg_wdata = 1'b0;

	nvob_in_req_t  quad_queue[$];
	nvob_out_req_t blend_expected[$];
	nvob_out_req_t want;
	bit            premul_mode = 1'b0;
	bit            quad_taken = 1'b0;
	bit            quiet = 1'b0;
	bit            hold_off = 1'b0;
	int            src_gap = 0;
	int            stall_left = 0;
	int            quads_taken = 0;
	int            premul_quads = 0;
	int            clear_quads = 0;
	int            results_seen = 0;
	int            blocked_cycles = 0;
	int            errors = 0;
	string         field_name[6] = '{"blended_top_left_luma", "blended_top_right_luma",
		"blended_bottom_left_luma", "blended_bottom_right_luma", "chroma_u_out", "chroma_v_out"};

	nv12_overlay_alpha_blend_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_req   (src_req),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_req   (dst_req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	function automatic int clamp_range(input int x, input int lo, input int hi);
		if (x < lo) return lo;
		if (x > hi) return hi;
		return x;
	endfunction

	function automatic int unpremultiply(input int c, input int a, input bit premul);
		int r;
		if (!premul || a == 0) return c;
		r = (c * 255 + a / 2) / a;
		return (r > 255) ? 255 : r;
	endfunction

	function automatic nvob_out_req_t blend_quad(input nvob_in_req_t q, input bit premul);
		logic [31:0] px[4];
		logic [7:0]  dl[4];
		logic [7:0]  lum[4];
		int a, b, g, r, y, su, sv, u, v, wu, wv, asum, ou, ov;
		px[0] = q.top_left_bgra;
		px[1] = q.top_right_bgra;
		px[2] = q.bottom_left_bgra;
		px[3] = q.bottom_right_bgra;
		dl[0] = q.top_left_luma;
		dl[1] = q.top_right_luma;
		dl[2] = q.bottom_left_luma;
		dl[3] = q.bottom_right_luma;
		wu = 0;
		wv = 0;
		asum = 0;
		for (int i = 0; i < 4; i++) begin
			a = px[i][31:24];
			b = unpremultiply(px[i][7:0], a, premul);
			g = unpremultiply(px[i][15:8], a, premul);
			r = unpremultiply(px[i][23:16], a, premul);
			y = clamp_range(16 + ((47 * r + 157 * g + 16 * b + 128) >> 8), 16, 235);
			su = -26 * r - 87 * g + 112 * b + 128;
			sv = 112 * r - 102 * g - 10 * b + 128;
			u = clamp_range((su + 32768) >>> 8, 16, 240);
			v = clamp_range((sv + 32768) >>> 8, 16, 240);
			lum[i] = 8'((y * a + int'(dl[i]) * (255 - a) + 127) / 255);
			wu += u * a;
			wv += v * a;
			asum += a;
		end
		ou = (wu + int'(q.chroma_u_in) * (1020 - asum) + 510) / 1020;
		ov = (wv + int'(q.chroma_v_in) * (1020 - asum) + 510) / 1020;
		return {lum[0], lum[1], lum[2], lum[3], 8'(ou), 8'(ov)};
	endfunction

	function automatic logic [31:0] pix(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic [7:0] a);
		return {a, r, g, b};
	endfunction

	function automatic nvob_in_req_t quad(input logic [31:0] p0, input logic [31:0] p1,
			input logic [31:0] p2, input logic [31:0] p3, input logic [47:0] dst);
		return {p0, p1, p2, p3, dst};
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_channel(input logic [7:0] a, input bit premul);
		if (premul && $urandom_range(0, 3) != 0) return 8'($urandom_range(0, a));
		return rand_byte();
	endfunction

	function automatic nvob_in_req_t rand_quad(input bit premul);
		logic [31:0] p[4];
		logic [7:0]  a;
		int          shape;
		shape = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++) begin
			case (shape)
				0: a = 8'd0;
				1: a = 8'd255;
				default: begin
					case ($urandom_range(0, 3))
						0: a = 8'd0;
						1: a = 8'd255;
						2: a = 8'($urandom_range(1, 15));
						default: a = 8'($urandom_range(0, 255));
					endcase
				end
			endcase
			p[i] = pix(rand_channel(a, premul), rand_channel(a, premul),
				rand_channel(a, premul), a);
		end
		return quad(p[0], p[1], p[2], p[3],
			{rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte()});
	endfunction

	task automatic add_quad(input nvob_in_req_t q);
		quad_queue.insert(quad_queue.size(), q);
	endtask

	task automatic load_directed();
		add_quad(quad(0, 0, 0, 0, 48'h0));
		add_quad(quad('1, '1, '1, '1, '1));
		add_quad(quad(pix(12, 200, 77, 0), pix(255, 255, 255, 0),
			pix(1, 2, 3, 0), pix(90, 0, 255, 0), 48'h10_EB_00_FF_37_C4));
		add_quad(quad(pix(255, 255, 255, 255), pix(255, 255, 255, 255),
			pix(255, 255, 255, 255), pix(255, 255, 255, 255), 48'h0));
		add_quad(quad(pix(0, 0, 0, 255), pix(0, 0, 0, 255),
			pix(0, 0, 0, 255), pix(0, 0, 0, 255), '1));
		add_quad(quad(pix(0, 0, 255, 255), pix(0, 255, 0, 255),
			pix(255, 0, 0, 255), pix(128, 128, 128, 255), 48'h10_80_EB_FF_00_FF));
		add_quad(quad(pix(255, 0, 0, 255), pix(255, 0, 0, 255),
			pix(255, 0, 0, 255), pix(255, 0, 0, 255), 48'h55_AA_55_AA_00_FF));
		add_quad(quad(pix(0, 0, 255, 255), pix(0, 0, 255, 255),
			pix(0, 0, 255, 255), pix(0, 0, 255, 255), 48'hAA_55_AA_55_FF_00));
		add_quad(quad(pix(40, 180, 220, 1), pix(40, 180, 220, 128),
			pix(40, 180, 220, 254), pix(40, 180, 220, 0), 48'hFF_00_80_7F_01_FE));
		add_quad(quad(pix(255, 255, 255, 1), pix(0, 0, 0, 254),
			pix(255, 0, 255, 2), pix(0, 255, 0, 253), 48'h00_FF_00_FF_80_80));
		add_quad(quad(pix(0, 0, 0, 255), pix(0, 0, 0, 0),
			pix(0, 0, 0, 0), pix(0, 0, 0, 0), 48'h01_02_04_08_10_20));
	endtask

	task automatic load_premul_directed();
		add_quad(quad(pix(200, 250, 255, 10), pix(11, 12, 13, 10),
			pix(1, 1, 1, 1), pix(2, 0, 255, 1), 48'h80_80_80_80_80_80));
		add_quad(quad(pix(9, 5, 3, 9), pix(0, 0, 0, 3),
			pix(128, 64, 32, 128), pix(100, 200, 255, 255), 48'h40_C0_20_E0_10_F0));
		add_quad(quad(pix(255, 255, 255, 254), pix(127, 127, 127, 127),
			pix(50, 51, 52, 50), pix(255, 255, 255, 0), 48'hFF_FF_00_00_FF_00));
	endtask

	task automatic write_mode(input bit m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (quad_queue.size() != 0 || src_valid || blend_expected.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!src_valid || quad_taken) begin
				quad_taken = 1'b0;
				if (src_gap != 0) begin
					src_gap--;
					src_valid <= 1'b0;
				end else if (quad_queue.size() != 0) begin
					src_req <= quad_queue.pop_front();
					src_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 10);
				end else begin
					src_valid <= 1'b0;
				end
			end
			if (hold_off) begin
				dst_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				dst_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 9);
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				blend_expected.insert(blend_expected.size(), blend_quad(src_req, premul_mode));
				quad_taken = 1'b1;
				quads_taken++;
				if (premul_mode) premul_quads++;
				if (src_req.top_left_bgra[31:24] == 0 && src_req.top_right_bgra[31:24] == 0 &&
						src_req.bottom_left_bgra[31:24] == 0 &&
						src_req.bottom_right_bgra[31:24] == 0)
					clear_quads++;
			end
			if (src_valid && src_stall) blocked_cycles++;
			if (dst_valid && !dst_stall) begin
				results_seen++;
				if (blend_expected.size() == 0) begin
					$display("%0t: unexpected result %h", $time, dst_req);
					errors++;
				end else begin
					want = blend_expected.pop_front();
					for (int i = 0; i < 6; i++) begin
						if (dst_req[47 - 8 * i -: 8] !== want[47 - 8 * i -: 8]) begin
							$display("%0t: %s expected %0d actual %0d", $time, field_name[i],
								want[47 - 8 * i -: 8], dst_req[47 - 8 * i -: 8]);
							errors++;
						end
					end
				end
			end
			if (cfg_we) premul_mode = cfg_wdata;
		end
	end

	initial begin
		wait (quads_taken >= 300);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#(12 * 300000);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_mode(ph[0]);
			if (ph == 0) load_directed();
			if (ph == 1) begin
				load_directed();
				load_premul_directed();
			end
			if (ph == 5) quiet = 1'b1;
			for (int n = 0; n < 150; n++) add_quad(rand_quad(ph[0]));
		end
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Blended %0d quads (%0d with premultiplied colour, %0d fully transparent).",
			quads_taken, premul_quads, clear_quads);
		$display("Checked %0d results; input blocked for %0d cycles; %0d mismatches.",
			results_seen, blocked_cycles, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> nv12_overlay_alpha_blend_core.f
+incdir+rtl
rtl/nvob_pkg.sv
rtl/nvob_unpremul.sv
rtl/nv12_overlay_alpha_blend_core.sv
rtl/nvob_checker.sv
tb/testbench.sv
